FILE: hdl/swm_pkg.sv
// shared types and constants of the sliding window maximum block
package swm_pkg;

  localparam int SMP_W     = 32;
  localparam int WIN_W     = 7;
  localparam int DEPTH_DEF = 64;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // register index of the window length
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic                    vld;
    logic signed [SMP_W-1:0] val;
  } cell_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_BUSY
  } state_t;

endpackage

FILE: hdl/sliding_window_maximum.sv
// Sliding window maximum over a stream of signed 32-bit samples. Each sample passes through
// ST_IDLE and then ST_BUSY: in ST_IDLE the sample is taken and the leaving sample is read from
// the history memory; in ST_BUSY the row of DEPTH deque cells compares every entry with the new
// sample in parallel and the result is written to the output register. ST_BUSY waits while an
// earlier result has not been taken, and no new sample is accepted until it is done. Results begin
// with the window_size-th sample of a sequence; tlast ends a sequence and clears the deque.
// window_size 0 acts as 1 and values above DEPTH act as DEPTH. No clearing pass after reset.
module sliding_window_maximum #(
  parameter int DEPTH = swm_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: sample[31:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,
  // in_tlast: last
  input  logic                        in_tlast,
  // out_tdata: window_max[31:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,
  // out_tlast: last_res
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [swm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [swm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [swm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import swm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int IDX_W = CNT_W + 1;

  state_t state_r, state_nxt;

  logic [WIN_W-1:0]        win_r;
  logic signed [SMP_W-1:0] smp_r;
  logic                    last_r;
  logic [CNT_W-1:0]        seen_r, seen_nxt;
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_max_r;
  logic                    out_last_r;

  logic                    in_fire;
  logic                    step;
  logic                    evict;
  logic                    produce;
  logic                    cfg_wr;
  logic                    cfg_sel;
  logic [CMP_W-1:0]        win_ext;
  logic [CNT_W-1:0]        w_eff;
  logic [IDX_W-1:0]        wr_ext, w_ext, rd_wide;
  logic [PTR_W-1:0]        rd_idx;
  logic signed [SMP_W-1:0] hist_q;

  cell_t cur  [DEPTH];
  cell_t a_v  [DEPTH];
  cell_t nxt  [DEPTH];
  logic  keep [DEPTH];
  logic  full;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_sel    = (cfg_paddr[CFG_AW-1:2] == REG_WINDOW_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_sel;
  assign cfg_prdata = cfg_sel ? CFG_DW'(win_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_W'(1);
    end else if (cfg_wr) begin
      win_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  // effective window length
  always_comb begin
    win_ext = CMP_W'(win_r);
    if (win_ext == '0) begin
      w_eff = CNT_W'(1);
    end else if (win_ext > CMP_W'(DEPTH)) begin
      w_eff = CNT_W'(DEPTH);
    end else begin
      w_eff = win_ext[CNT_W-1:0];
    end
  end

  // history slot of the sample leaving the window
  always_comb begin
    wr_ext = IDX_W'(wr_ptr_r);
    w_ext  = IDX_W'(w_eff);
    if (wr_ext >= w_ext) begin
      rd_wide = wr_ext - w_ext;
    end else begin
      rd_wide = wr_ext + IDX_W'(DEPTH) - w_ext;
    end
    rd_idx = rd_wide[PTR_W-1:0];
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  swm_history #(
    .DEPTH (DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (step),
    .wr_addr (wr_ptr_r),
    .wr_data (smp_r),
    .rd_en   (in_fire),
    .rd_addr (rd_idx),
    .rd_data (hist_q)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r  <= in_tdata;
      last_r <= in_tlast;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (!out_valid_r || out_tready) begin
          step      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign evict = (seen_r >= w_eff) && cur[0].vld && (cur[0].val == hist_q);
  assign full  = keep[DEPTH-1];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_t nb1_w, nb_a_w;
      logic  prev_keep_w;
      if (gi < DEPTH - 1) begin : g_mid
        assign nb1_w  = cur[gi+1];
        assign nb_a_w = a_v[gi+1];
      end else begin : g_tail
        assign nb1_w.vld  = 1'b0;
        assign nb1_w.val  = '0;
        assign nb_a_w.vld = 1'b1;
        assign nb_a_w.val = smp_r;
      end
      if (gi == 0) begin : g_head
        assign prev_keep_w = 1'b1;
      end else begin : g_body
        assign prev_keep_w = keep[gi-1];
      end
      swm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .clear     (step && last_r),
        .evict     (evict),
        .full      (full),
        .prev_keep (prev_keep_w),
        .smp       (smp_r),
        .nb1       (nb1_w),
        .nb_a      (nb_a_w),
        .cur       (cur[gi]),
        .a_out     (a_v[gi]),
        .keep      (keep[gi]),
        .nxt       (nxt[gi])
      );
    end
  endgenerate

  always_comb begin
    seen_nxt = (seen_r < CNT_W'(DEPTH)) ? seen_r + CNT_W'(1) : seen_r;
    produce  = (seen_nxt >= w_eff);
    if (wr_ptr_r == PTR_W'(DEPTH - 1)) begin
      wr_ptr_nxt = '0;
    end else begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      wr_ptr_r <= '0;
    end else if (step) begin
      if (last_r) begin
        seen_r   <= '0;
        wr_ptr_r <= '0;
      end else begin
        seen_r   <= seen_nxt;
        wr_ptr_r <= wr_ptr_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= produce;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      out_max_r  <= nxt[0].val;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_max_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/swm_cell.sv
// one deque cell: holds one candidate maximum and takes data from its neighbors
module swm_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic                              clear,
  input  logic                              evict,
  input  logic                              full,
  input  logic                              prev_keep,
  input  logic signed [swm_pkg::SMP_W-1:0]  smp,
  input  swm_pkg::cell_t                    nb1,
  input  swm_pkg::cell_t                    nb_a,
  output swm_pkg::cell_t                    cur,
  output swm_pkg::cell_t                    a_out,
  output logic                              keep,
  output swm_pkg::cell_t                    nxt
);
  import swm_pkg::*;

  cell_t cell_r;
  cell_t cell_nxt;
  cell_t after_ev;

  always_comb begin
    after_ev = evict ? nb1 : cell_r;
    keep     = after_ev.vld && !(smp > after_ev.val);
    if (full) begin
      // deque stays at full depth: everything moves one more toward the front
      cell_nxt = nb_a;
    end else if (keep) begin
      cell_nxt = after_ev;
    end else if (prev_keep) begin
      cell_nxt.vld = 1'b1;
      cell_nxt.val = smp;
    end else begin
      cell_nxt.vld = 1'b0;
      cell_nxt.val = after_ev.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (clear) begin
      cell_r.vld <= 1'b0;
    end else if (step) begin
      cell_r <= cell_nxt;
    end
  end

  assign cur   = cell_r;
  assign a_out = after_ev;
  assign nxt   = cell_nxt;

endmodule

FILE: hdl/swm_history.sv
// ring memory of recent samples with registered read
module swm_history #(
  parameter int DEPTH = swm_pkg::DEPTH_DEF,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [PTR_W-1:0]                  wr_addr,
  input  logic signed [swm_pkg::SMP_W-1:0]  wr_data,
  input  logic                              rd_en,
  input  logic [PTR_W-1:0]                  rd_addr,
  output logic signed [swm_pkg::SMP_W-1:0]  rd_data
);
  import swm_pkg::*;

  logic signed [SMP_W-1:0] mem [DEPTH];
  logic signed [SMP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the sliding window maximum block
`timescale 1ns / 1ps

module tb_top;
  import swm_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RAND_ITEMS   = 350;
  localparam int SETTLE       = 8;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CFG_AW-1:0] WIN_ADDR = CFG_AW'(4 * REG_WINDOW_SIZE);

  typedef struct {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } sample_req_t;

  typedef struct {
    logic signed [SMP_W-1:0] window_max;
    logic                    last_res;
  } max_res_t;

  typedef enum int {
    STY_FULL,
    STY_NARROW,
    STY_EXTREME,
    STY_FALLING,
    STY_RISING,
    STY_MIX
  } style_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;
  logic                out_tlast;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  sliding_window_maximum #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // pending samples and expected window maxima
  sample_req_t feed_q[$];
  max_res_t    max_q[$];

  // predictor state
  logic [WIN_W-1:0]        win_reg = 7'd1;
  logic signed [SMP_W-1:0] dq[DEPTH];
  int                      dq_cnt = 0;
  logic signed [SMP_W-1:0] hist[DEPTH];
  int                      seen = 0;
  int                      wptr = 0;

  int                      errors = 0;
  int                      cycles = 0;
  bit                      tx_idle = 1'b1;
  bit                      rx_idle = 1'b1;
  int                      hold_trigger = 0;
  int                      hold_seen = 0;
  int                      rx_stall = 0;
  int                      in_gap = 0;
  bit                      in_took = 1'b0;
  logic signed [SMP_W-1:0] run_val = 0;
  sample_req_t             tx_req;
  max_res_t                want;

  function automatic void drop_front();
    if (dq_cnt == 0) return;
    for (int i = 0; i < dq_cnt - 1; i++) dq[i] = dq[i+1];
    dq_cnt--;
  endfunction

  function automatic void predict_max(input logic signed [SMP_W-1:0] s, input logic lst);
    int       w;
    int       idx;
    max_res_t r;
    w = (win_reg == 0) ? 1 : ((int'(win_reg) > DEPTH) ? DEPTH : int'(win_reg));
    // the sample leaving the window goes only if it is still at the front
    if (seen >= w) begin
      idx = (wptr + DEPTH - w) % DEPTH;
      if (dq_cnt > 0 && dq[0] == hist[idx]) drop_front();
    end
    while (dq_cnt > 0 && s > dq[dq_cnt-1]) dq_cnt--;
    if (dq_cnt >= DEPTH) drop_front();
    dq[dq_cnt] = s;
    dq_cnt++;
    hist[wptr] = s;
    wptr = (wptr + 1) % DEPTH;
    if (seen < DEPTH) seen++;
    if (seen >= w) begin
      r.window_max = dq[0];
      r.last_res   = lst;
      max_q.insert(max_q.size(), r);
    end
    if (lst) begin
      dq_cnt = 0;
      seen   = 0;
      wptr   = 0;
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // sender: offers samples at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_max(in_tdata, in_tlast);
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        tx_req = feed_q[0];
        feed_q.delete(0);
        in_tvalid <= 1'b1;
        in_tdata  <= tx_req.sample;
        in_tlast  <= tx_req.last;
        in_gap    = pick_gap(tx_idle);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      rx_stall  = LONG_HOLD;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_stall   = pick_gap(rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (max_q.size() == 0) begin
        $error("window_max %0d arrived with no expectation", $signed(out_tdata));
        errors++;
      end else begin
        want = max_q[0];
        max_q.delete(0);
        if (out_tdata !== want.window_max) begin
          $error("window_max: expected %0d, got %0d", want.window_max, $signed(out_tdata));
          errors++;
        end
        if (out_tlast !== want.last_res) begin
          $error("last_res: expected %0b, got %0b", want.last_res, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic apb_xfer(input logic wr, input logic [CFG_DW-1:0] wdata,
                          output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = WIN_ADDR;
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_window(input int v);
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b1, CFG_DW'(v), rd);
    win_reg = v[WIN_W-1:0];
    apb_xfer(1'b0, '0, rd);
    if (rd !== CFG_DW'(v[WIN_W-1:0])) begin
      $error("window_size readback: expected %0d, got %0d", v[WIN_W-1:0], rd);
      errors++;
    end
  endtask

  task automatic wait_drained();
    while (feed_q.size() != 0 || in_tvalid || max_q.size() != 0) @(posedge clk);
    // a sample with no result may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_sample(input logic signed [SMP_W-1:0] s, input logic lst);
    sample_req_t r;
    r.sample = s;
    r.last   = lst;
    feed_q.insert(feed_q.size(), r);
  endtask

  task automatic queue_seq(input int len, input style_t style, input bit close);
    logic signed [SMP_W-1:0] v;
    style_t                  sty;
    v = run_val;
    for (int i = 0; i < len; i++) begin
      sty = (style == STY_MIX) ? style_t'($urandom_range(4)) : style;
      case (sty)
        STY_NARROW:  v = int'($urandom_range(6)) - 3;
        STY_EXTREME: begin
          case ($urandom_range(3))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = 0;
            default: v = -1;
          endcase
        end
        STY_FALLING: v = v - int'($urandom_range(3, 1));
        STY_RISING:  v = v + int'($urandom_range(3));
        default:     v = $urandom;
      endcase
      add_sample(v, close && (i == len - 1));
    end
    run_val = v;
  endtask

  initial begin
    int w;
    int weff;
    int nseq;
    int len;
    int rand_items;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      dq[i]   = 0;
      hist[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset window of one: every sample is its own maximum
    begin
      logic [CFG_DW-1:0] rd;
      apb_xfer(1'b0, '0, rd);
      if (rd !== CFG_DW'(1)) begin
        $error("window_size after reset: expected 1, got %0d", rd);
        errors++;
      end
    end
    add_sample(32'sh8000_0000, 1'b0);
    add_sample(32'sh7fff_ffff, 1'b0);
    add_sample(0, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(32'sh8000_0000, 1'b1);
    wait_drained();

    // equal values stay in the deque, falling run evicts from the front
    set_window(3);
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(7, 1'b0);
    add_sample(7, 1'b0);
    add_sample(9, 1'b0);
    add_sample(8, 1'b0);
    add_sample(7, 1'b0);
    add_sample(6, 1'b1);
    // sequence shorter than the window
    add_sample(1, 1'b0);
    add_sample(2, 1'b1);
    wait_drained();

    // zero acts as one
    set_window(0);
    add_sample(-5, 1'b0);
    add_sample(3, 1'b0);
    add_sample(-7, 1'b1);
    wait_drained();

    // oversized window clamps to the deque depth
    set_window(127);
    add_sample(4, 1'b0);
    add_sample(32'sh7fff_ffff, 1'b0);
    add_sample(-4, 1'b1);
    wait_drained();

    // fill the deque with a strictly falling run while the receiver holds off,
    // then shrink the window mid-sequence so the full deque drops its front
    set_window(DEPTH);
    run_val = 32'sh4000_0000;
    hold_trigger++;
    queue_seq(DEPTH + 2, STY_FALLING, 1'b0);
    wait_drained();
    set_window(4);
    queue_seq(8, STY_FALLING, 1'b1);
    wait_drained();

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(9))
        0:       w = 0;
        1:       w = $urandom_range(127, DEPTH);
        default: w = $urandom_range(12, 1);
      endcase
      weff    = (w == 0) ? 1 : ((w > DEPTH) ? DEPTH : w);
      tx_idle = ($urandom_range(3) != 0);
      rx_idle = ($urandom_range(3) != 0);
      set_window(w);
      nseq = (weff > 16) ? 1 : $urandom_range(4, 1);
      if ($urandom_range(9) == 0) hold_trigger++;
      for (int k = 0; k < nseq; k++) begin
        if ($urandom_range(99) < 15) len = $urandom_range(weff, 1);
        else len = weff + $urandom_range(12);
        run_val = $urandom;
        queue_seq(len, style_t'($urandom_range(5)), 1'b1);
        rand_items += len;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
